@@ rtl/aatb_pkg.sv @@
package aatb_pkg;

	localparam int TABLE_CAP = 256;
	localparam int TIDX_W    = 8;
	localparam int TCNT_W    = 9;
	localparam int FREQ_W    = 13;
	localparam int CUT_W     = 16;
	localparam int ALU_W     = FREQ_W + TIDX_W;
	localparam int AB_MAX    = 8;

	localparam int DEF_MAX_SYMBOLS = 256;
	localparam int DEF_RANGE_BITS  = 12;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TOO_MANY = 3'd1;
	localparam logic [2:0] ST_SUM      = 3'd2;
	localparam logic [2:0] ST_TWO_FULL = 3'd3;
	localparam logic [2:0] ST_NO_UNDER = 3'd4;

	localparam logic [0:0] REG_ALPHABET_BITS = 1'd0;

	// committed table entry
	typedef struct packed {
		logic [7:0]        cutoff;
		logic [7:0]        right;
		logic [15:0]       offset;
		logic [FREQ_W-1:0] freq0;
		logic [FREQ_W-1:0] fxor;
	} entry_t;

	// working entry used while pairing buckets
	typedef struct packed {
		logic [CUT_W-1:0]  cut;
		logic [7:0]        right;
		logic [15:0]       offset;
		logic [FREQ_W-1:0] freq0;
	} work_t;

	// request to the shared adder: y = a + b - c
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic [ALU_W-1:0] c;
	} alu_req_t;

endpackage

@@ rtl/aatb_ram.sv @@
module aatb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/aatb_alu.sv @@
module aatb_alu (
	input  aatb_pkg::alu_req_t         req,
	output logic [aatb_pkg::ALU_W-1:0] y
);

	import aatb_pkg::*;

	// add two operands and take off a third
	assign y = req.a + req.b - req.c;

endmodule

@@ rtl/ans_alias_table_builder_core.sv @@
// Alias table builder for an ANS decoder. A load word appends a symbol frequency.
// A read word presents its entry on the output after the registered table read in
// S_RD_WAIT and the S_DONE state. A build word runs a sequencer around one shared
// add/subtract unit and one-write, one-read memories: it trims trailing zeros, sums
// the loaded symbols for the sum check, fills the stacks from each table entry,
// pairs overfull with underfull buckets, and writes all 256 entries of the new
// table into the spare bank, which is swapped in only when the build succeeds. No
// new word is taken while a build runs. No clearing pass runs after reset.
module ans_alias_table_builder_core #(
	parameter int MAX_SYMBOLS = aatb_pkg::DEF_MAX_SYMBOLS,
	parameter int RANGE_BITS  = aatb_pkg::DEF_RANGE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [12:0] frequency,
	input  logic [7:0]  entry_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  cutoff,
	output logic [7:0]  right_symbol,
	output logic [15:0] alias_offset,
	output logic [12:0] base_frequency,
	output logic [12:0] frequency_xor,
	output logic        is_read_result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import aatb_pkg::*;

	localparam int CNT_W     = $clog2(MAX_SYMBOLS + 1);
	localparam int FA_W      = $clog2(MAX_SYMBOLS);
	localparam int SUM_W     = FREQ_W + $clog2(MAX_SYMBOLS);
	localparam int RANGE_VAL = 1 << RANGE_BITS;

	typedef enum logic [4:0] {
		S_IDLE, S_RD_WAIT, S_DONE,
		S_TRIM_RD, S_TRIM_CHK, S_CHECK, S_SUM_RD, S_SUM_CHK, S_SUM_END,
		S_INIT_RD, S_INIT_WR, S_POP, S_GET_U, S_GET_O, S_PUT_U, S_PUT_O,
		S_FIN_RD, S_FIN_MID, S_FIN_WR
	} state_t;

	state_t             state_q;
	logic [3:0]         ab_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   size_q;
	logic [TCNT_W-1:0]  idx_q;
	logic [SUM_W-1:0]   sum_q;
	logic               have_single_q;
	logic               two_full_q;
	logic [7:0]         sym_q;
	logic               uniform_q;
	logic [TCNT_W-1:0]  udep_q;
	logic [TCNT_W-1:0]  odep_q;
	logic [7:0]         o_q;
	logic [7:0]         u_q;
	work_t              u_ent_q;
	work_t              o_ent_q;
	logic [CUT_W-1:0]   newcut_q;
	logic [7:0]         fin_cut_q;
	logic [7:0]         fin_right_q;
	logic [15:0]        fin_off_q;
	logic [FREQ_W-1:0]  fin_f0_q;
	logic               bank_q;
	logic [2:0]         status_q;
	logic               res_read_q;
	entry_t             res_ent_q;
	logic               out_valid_q;

	logic [3:0]         ab_eff;
	logic [TCNT_W-1:0]  tsize;
	logic [CUT_W-1:0]   range16;
	logic [CUT_W-1:0]   esize;
	logic               in_acc;
	logic               out_free;

	logic               f_we;
	logic [FA_W-1:0]    f_waddr;
	logic [FA_W-1:0]    f_raddr;
	logic [FREQ_W-1:0]  f_rdata;

	logic               w_we;
	logic [TIDX_W-1:0]  w_waddr;
	work_t              w_wdata;
	logic [TIDX_W-1:0]  w_raddr;
	work_t              w_rdata;

	logic               us_we;
	logic [TIDX_W-1:0]  us_waddr;
	logic [7:0]         us_wdata;
	logic [7:0]         us_rdata;
	logic               os_we;
	logic [TIDX_W-1:0]  os_waddr;
	logic [7:0]         os_wdata;
	logic [7:0]         os_rdata;

	logic               t_we;
	logic [TIDX_W:0]    t_waddr;
	entry_t             t_wdata;
	logic [TIDX_W:0]    t_raddr;
	entry_t             t_rdata;

	alu_req_t           alu_req;
	logic [ALU_W-1:0]   alu_y;

	logic [CUT_W-1:0]   init_c;
	logic               mid_full;
	logic [7:0]         mid_right;
	logic [3:0]         ushift;
	logic [15:0]        uoff;

	// derive table geometry from the register
	assign ab_eff   = (ab_q > 4'(AB_MAX)) ? 4'(AB_MAX) : ab_q;
	assign tsize    = TCNT_W'(1) << ab_eff;
	assign range16  = CUT_W'(RANGE_VAL);
	assign esize    = range16 >> ab_eff;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_ALPHABET_BITS) ? {28'd0, ab_q} : 32'd0;

	assign init_c    = (idx_q < TCNT_W'(size_q)) ? CUT_W'(f_rdata) : '0;
	assign mid_full  = (w_rdata.cut == esize);
	assign mid_right = mid_full ? idx_q[7:0] : w_rdata.right;
	assign ushift    = 4'(RANGE_BITS) - ab_eff;
	assign uoff      = 16'(idx_q[7:0]) << ushift;

	// frequency store
	assign f_we    = in_acc & (opcode == OP_LOAD) & (count_q < CNT_W'(MAX_SYMBOLS));
	assign f_waddr = count_q[FA_W-1:0];
	assign f_raddr = (state_q == S_TRIM_RD) ? FA_W'(size_q - 1'b1) : idx_q[FA_W-1:0];

	aatb_ram #(.WIDTH(FREQ_W), .DEPTH(MAX_SYMBOLS)) u_freq (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(frequency),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	// shared adder operands
	always_comb begin
		alu_req = '0;
		case (state_q)
			S_SUM_CHK: begin
				alu_req.a = ALU_W'(sum_q);
				alu_req.b = ALU_W'(f_rdata);
			end
			S_PUT_U: begin
				alu_req.a = ALU_W'(w_rdata.cut);
				alu_req.b = ALU_W'(u_ent_q.cut);
				alu_req.c = ALU_W'(esize);
			end
			S_FIN_MID: begin
				alu_req.a = ALU_W'(w_rdata.offset);
				alu_req.c = ALU_W'(w_rdata.cut);
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	aatb_alu u_alu (.req(alu_req), .y(alu_y));

	// working table ports
	always_comb begin
		w_we    = 1'b0;
		w_waddr = idx_q[7:0];
		w_wdata = '0;
		w_raddr = idx_q[7:0];
		case (state_q)
			S_INIT_WR: begin
				w_we          = 1'b1;
				w_wdata.cut   = init_c;
				w_wdata.freq0 = FREQ_W'(init_c);
			end
			S_GET_U: w_raddr = us_rdata;
			S_GET_O: w_raddr = o_q;
			S_PUT_U: begin
				w_we           = 1'b1;
				w_waddr        = u_q;
				w_wdata        = u_ent_q;
				w_wdata.right  = o_q;
				w_wdata.offset = 16'(alu_y);
			end
			S_PUT_O: begin
				w_we        = 1'b1;
				w_waddr     = o_q;
				w_wdata     = o_ent_q;
				w_wdata.cut = newcut_q;
			end
			S_FIN_MID: w_raddr = mid_right;
			default: begin
				w_we = 1'b0;
			end
		endcase
	end

	aatb_ram #(.WIDTH($bits(work_t)), .DEPTH(TABLE_CAP)) u_work (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	// stack pushes
	always_comb begin
		us_we    = 1'b0;
		os_we    = 1'b0;
		us_waddr = udep_q[7:0];
		os_waddr = odep_q[7:0];
		us_wdata = idx_q[7:0];
		os_wdata = idx_q[7:0];
		case (state_q)
			S_INIT_WR: begin
				os_we = (init_c > esize);
				us_we = (init_c < esize);
			end
			S_PUT_O: begin
				us_wdata = o_q;
				os_wdata = o_q;
				us_we    = (newcut_q < esize);
				os_we    = (newcut_q > esize);
			end
			default: begin
				us_we = 1'b0;
			end
		endcase
	end

	aatb_ram #(.WIDTH(8), .DEPTH(TABLE_CAP)) u_ustack (
		.clk(clk), .we(us_we), .waddr(us_waddr), .wdata(us_wdata),
		.raddr(TIDX_W'(udep_q - 1'b1)), .rdata(us_rdata)
	);

	aatb_ram #(.WIDTH(8), .DEPTH(TABLE_CAP)) u_ostack (
		.clk(clk), .we(os_we), .waddr(os_waddr), .wdata(os_wdata),
		.raddr(TIDX_W'(odep_q - 1'b1)), .rdata(os_rdata)
	);

	// committed table, two banks
	always_comb begin
		t_we    = (state_q == S_FIN_WR);
		t_waddr = {~bank_q, idx_q[7:0]};
		t_raddr = {bank_q, entry_index};
		t_wdata = '0;
		if (idx_q < tsize) begin
			if (uniform_q) begin
				t_wdata.right  = sym_q;
				t_wdata.offset = uoff;
				t_wdata.fxor   = FREQ_W'(RANGE_VAL);
			end else begin
				t_wdata.cutoff = fin_cut_q;
				t_wdata.right  = fin_right_q;
				t_wdata.offset = fin_off_q;
				t_wdata.freq0  = fin_f0_q;
				t_wdata.fxor   = w_rdata.freq0 ^ fin_f0_q;
			end
		end
	end

	aatb_ram #(.WIDTH($bits(entry_t)), .DEPTH(2 * TABLE_CAP)) u_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ab_q          <= 4'd8;
			count_q       <= '0;
			ovf_q         <= 1'b0;
			size_q        <= '0;
			idx_q         <= '0;
			sum_q         <= '0;
			have_single_q <= 1'b0;
			two_full_q    <= 1'b0;
			sym_q         <= '0;
			uniform_q     <= 1'b0;
			udep_q        <= '0;
			odep_q        <= '0;
			bank_q        <= 1'b0;
			status_q      <= ST_OK;
			res_read_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_ALPHABET_BITS) begin
				ab_q <= pwdata[3:0];
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (opcode)
							OP_LOAD: begin
								if (count_q < CNT_W'(MAX_SYMBOLS)) begin
									count_q <= count_q + 1'b1;
								end else if (frequency != '0) begin
									ovf_q <= 1'b1;
								end
							end
							OP_BUILD: begin
								size_q        <= count_q;
								count_q       <= '0;
								ovf_q         <= 1'b0;
								sum_q         <= '0;
								have_single_q <= 1'b0;
								two_full_q    <= 1'b0;
								res_read_q    <= 1'b0;
								res_ent_q     <= '0;
								if (ovf_q) begin
									status_q <= ST_TOO_MANY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_TRIM_RD;
								end
							end
							OP_READ: state_q <= S_RD_WAIT;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RD_WAIT: begin
					res_ent_q  <= t_rdata;
					res_read_q <= 1'b1;
					status_q   <= ST_OK;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TRIM_RD: begin
					state_q <= (size_q == '0) ? S_CHECK : S_TRIM_CHK;
				end
				S_TRIM_CHK: begin
					if (f_rdata == '0) begin
						size_q  <= size_q - 1'b1;
						state_q <= S_TRIM_RD;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					idx_q <= '0;
					if (size_q == '0) begin
						uniform_q <= 1'b1;
						sym_q     <= '0;
						state_q   <= S_FIN_RD;
					end else if (TCNT_W'(size_q) > tsize) begin
						status_q <= ST_TOO_MANY;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_SUM_RD;
					end
				end
				S_SUM_RD: state_q <= S_SUM_CHK;
				S_SUM_CHK: begin
					sum_q <= SUM_W'(alu_y);
					if (CUT_W'(f_rdata) == range16) begin
						if (have_single_q) begin
							two_full_q <= 1'b1;
						end
						have_single_q <= 1'b1;
						sym_q         <= idx_q[7:0];
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q + 1'b1 == TCNT_W'(size_q)) ? S_SUM_END : S_SUM_RD;
				end
				S_SUM_END: begin
					idx_q  <= '0;
					udep_q <= '0;
					odep_q <= '0;
					if (two_full_q) begin
						status_q <= ST_TWO_FULL;
						state_q  <= S_DONE;
					end else if (sum_q != SUM_W'(RANGE_VAL)) begin
						status_q <= ST_SUM;
						state_q  <= S_DONE;
					end else if (have_single_q) begin
						uniform_q <= 1'b1;
						state_q   <= S_FIN_RD;
					end else begin
						uniform_q <= 1'b0;
						state_q   <= S_INIT_RD;
					end
				end
				S_INIT_RD: state_q <= S_INIT_WR;
				S_INIT_WR: begin
					if (init_c > esize) begin
						odep_q <= odep_q + 1'b1;
					end else if (init_c < esize) begin
						udep_q <= udep_q + 1'b1;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q == tsize - 1'b1) ? S_POP : S_INIT_RD;
				end
				S_POP: begin
					if (odep_q == '0) begin
						idx_q   <= '0;
						state_q <= S_FIN_RD;
					end else if (udep_q == '0) begin
						status_q <= ST_NO_UNDER;
						state_q  <= S_DONE;
					end else begin
						odep_q  <= odep_q - 1'b1;
						udep_q  <= udep_q - 1'b1;
						state_q <= S_GET_U;
					end
				end
				S_GET_U: begin
					o_q     <= os_rdata;
					u_q     <= us_rdata;
					state_q <= S_GET_O;
				end
				S_GET_O: begin
					u_ent_q <= w_rdata;
					state_q <= S_PUT_U;
				end
				S_PUT_U: begin
					o_ent_q  <= w_rdata;
					newcut_q <= CUT_W'(alu_y);
					state_q  <= S_PUT_O;
				end
				S_PUT_O: begin
					if (newcut_q < esize) begin
						udep_q <= udep_q + 1'b1;
					end else if (newcut_q > esize) begin
						odep_q <= odep_q + 1'b1;
					end
					state_q <= S_POP;
				end
				S_FIN_RD: state_q <= S_FIN_MID;
				S_FIN_MID: begin
					fin_right_q <= mid_right;
					fin_f0_q    <= w_rdata.freq0;
					fin_off_q   <= mid_full ? 16'd0 : 16'(alu_y);
					fin_cut_q   <= mid_full ? 8'd0 : w_rdata.cut[7:0];
					state_q     <= S_FIN_WR;
				end
				S_FIN_WR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q[7:0] == 8'hFF) begin
						bank_q   <= ~bank_q;
						status_q <= ST_OK;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FIN_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// drive result word
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status         <= status_q;
			cutoff         <= res_ent_q.cutoff;
			right_symbol   <= res_ent_q.right;
			alias_offset   <= res_ent_q.offset;
			base_frequency <= res_ent_q.freq0;
			frequency_xor  <= res_ent_q.fxor;
			is_read_result <= res_read_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import aatb_pkg::*;

	localparam int RANGE     = 1 << DEF_RANGE_BITS;
	localparam int N_RANDOM  = 1000;
	localparam int TAIL_WAIT = 1200;

	// one result word as seen on the output channel
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  cutoff;
		logic [7:0]  right_symbol;
		logic [15:0] alias_offset;
		logic [12:0] base_frequency;
		logic [12:0] frequency_xor;
		logic        is_read_result;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [12:0] frequency;
	logic [7:0]  entry_index;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [7:0]  cutoff;
	logic [7:0]  right_symbol;
	logic [15:0] alias_offset;
	logic [12:0] base_frequency;
	logic [12:0] frequency_xor;
	logic        is_read_result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ans_alias_table_builder_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .frequency(frequency), .entry_index(entry_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .cutoff(cutoff), .right_symbol(right_symbol),
		.alias_offset(alias_offset), .base_frequency(base_frequency),
		.frequency_xor(frequency_xor), .is_read_result(is_read_result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [3:0]  alpha_reg;
	logic [12:0] freq_mem [TABLE_CAP];
	int          load_cnt;
	bit          load_ovf;
	entry_t      alias_tbl [TABLE_CAP];
	bit          tbl_built;

	result_t     expected_q [$];
	int          fail_cnt;
	bit          idle_on;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("tb_top failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_cnt++;
	endtask

	// compute a build into alias_tbl; return status
	function automatic logic [2:0] build_alias();
		int     ab, tsize, esize, size, sum, single, ud, od, o, u, i;
		bit     have_single;
		int     cut [TABLE_CAP];
		int     ustk [TABLE_CAP];
		int     ostk [TABLE_CAP];
		entry_t wt [TABLE_CAP];
		ab = (alpha_reg > 8) ? 8 : alpha_reg;
		tsize = 1 << ab;
		esize = RANGE >> ab;
		size = load_cnt;
		sum = 0;
		single = 0;
		have_single = 0;
		ud = 0;
		od = 0;
		for (i = 0; i < TABLE_CAP; i++) wt[i] = '0;
		while (size != 0 && freq_mem[size-1] == 0) size--;
		if (load_ovf) return ST_TOO_MANY;
		if (size == 0) begin
			for (i = 0; i < tsize; i++) begin
				wt[i].offset = 16'(esize * i);
				wt[i].fxor = 13'(RANGE);
			end
			alias_tbl = wt;
			return ST_OK;
		end
		if (size > tsize) return ST_TOO_MANY;
		for (i = 0; i < size; i++) begin
			sum += freq_mem[i];
			if (freq_mem[i] == RANGE) begin
				if (have_single) return ST_TWO_FULL;
				have_single = 1;
				single = i;
			end
		end
		if (sum != RANGE) return ST_SUM;
		if (have_single) begin
			for (i = 0; i < tsize; i++) begin
				wt[i].right = 8'(single);
				wt[i].offset = 16'(esize * i);
				wt[i].fxor = 13'(RANGE);
			end
			alias_tbl = wt;
			return ST_OK;
		end
		// sort buckets onto the two stacks
		for (i = 0; i < tsize; i++) begin
			cut[i] = (i < size) ? freq_mem[i] : 0;
			wt[i].freq0 = 13'(cut[i]);
			if (cut[i] > esize) ostk[od++] = i;
			else if (cut[i] < esize) ustk[ud++] = i;
		end
		// pair overfull with underfull
		while (od != 0) begin
			o = ostk[--od];
			if (ud == 0) return ST_NO_UNDER;
			u = ustk[--ud];
			cut[o] = cut[o] - (esize - cut[u]);
			wt[u].right = 8'(o);
			wt[u].offset = 16'(cut[o]);
			if (cut[o] < esize) ustk[ud++] = o;
			else if (cut[o] > esize) ostk[od++] = o;
		end
		for (i = 0; i < tsize; i++) begin
			if (cut[i] == esize) begin
				wt[i].right = 8'(i);
				wt[i].offset = '0;
				wt[i].cutoff = '0;
			end else begin
				wt[i].offset = 16'(int'(wt[i].offset) - cut[i]);
				wt[i].cutoff = 8'(cut[i]);
			end
		end
		for (i = 0; i < tsize; i++)
			wt[i].fxor = wt[wt[i].right].freq0 ^ wt[i].freq0;
		alias_tbl = wt;
		return ST_OK;
	endfunction

	// advance the predictor by one accepted word
	task automatic predict_word(input logic [1:0] op, input logic [12:0] f,
			input logic [7:0] idx);
		result_t r;
		r = '0;
		case (op)
			OP_LOAD: begin
				if (load_cnt < DEF_MAX_SYMBOLS) freq_mem[load_cnt++] = f;
				else if (f != 0) load_ovf = 1;
			end
			OP_BUILD: begin
				r.status = build_alias();
				if (r.status == ST_OK) tbl_built = 1;
				load_cnt = 0;
				load_ovf = 0;
				expected_q.insert(expected_q.size(), r);
			end
			OP_READ: begin
				r.cutoff = alias_tbl[idx].cutoff;
				r.right_symbol = alias_tbl[idx].right;
				r.alias_offset = alias_tbl[idx].offset;
				r.base_frequency = alias_tbl[idx].freq0;
				r.frequency_xor = alias_tbl[idx].fxor;
				r.is_read_result = 1'b1;
				expected_q.insert(expected_q.size(), r);
			end
			default: ;
		endcase
	endtask

	// send one word, with optional idle burst first
	task automatic send_word(input logic [1:0] op, input logic [12:0] f,
			input logic [7:0] idx);
		if (op == OP_READ && !tbl_built) return;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		frequency <= f;
		entry_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_word(op, f, idx);
		@(negedge clk);
	endtask

	// drop valid and wait for the block to drain
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (TAIL_WAIT) @(negedge clk);
	endtask

	task automatic write_alphabet_bits(input logic [3:0] v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_ALPHABET_BITS);
		pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		alpha_reg = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// load a valid distribution summing to range over n symbols
	task automatic load_valid(input int n);
		int left, i, f;
		left = RANGE;
		for (i = 0; i < n; i++) begin
			f = (i == n - 1) ? left : $urandom_range(0, left);
			left -= f;
			send_word(OP_LOAD, 13'(f), 8'($urandom));
		end
	endtask

	task automatic read_some(input int n);
		repeat (n) send_word(OP_READ, 13'($urandom), 8'($urandom));
	endtask

	// compare each result against the oldest expectation
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, cutoff, right_symbol, alias_offset, base_frequency,
				frequency_xor, is_read_result};
			if (expected_q.size() == 0) begin
				$display("unexpected result word");
				fail_cnt++;
			end else begin
				want = expected_q.pop_front();
				if (got.status != want.status)
					report_mismatch("status", got.status, want.status);
				if (got.cutoff != want.cutoff)
					report_mismatch("cutoff", got.cutoff, want.cutoff);
				if (got.right_symbol != want.right_symbol)
					report_mismatch("right_symbol", got.right_symbol, want.right_symbol);
				if (got.alias_offset != want.alias_offset)
					report_mismatch("alias_offset", got.alias_offset, want.alias_offset);
				if (got.base_frequency != want.base_frequency)
					report_mismatch("base_frequency", got.base_frequency,
						want.base_frequency);
				if (got.frequency_xor != want.frequency_xor)
					report_mismatch("frequency_xor", got.frequency_xor, want.frequency_xor);
				if (got.is_read_result != want.is_read_result)
					report_mismatch("is_read_result", got.is_read_result,
						want.is_read_result);
			end
		end
	end

	// random receiver stalls
	always @(negedge clk) begin
		if (!idle_on) out_stall <= 1'b0;
		else if (!out_stall && $urandom_range(0, 5) == 0) out_stall <= 1'b1;
		else if (out_stall && $urandom_range(0, 2) == 0) out_stall <= 1'b0;
	end

	task automatic test_directed();
		int i;
		// empty build, then read extremes
		send_word(OP_BUILD, '0, '0);
		send_word(OP_READ, '0, 8'd0);
		send_word(OP_READ, '0, 8'd255);
		// single full symbol with a leading and a trailing zero
		send_word(OP_LOAD, 13'd0, '0);
		send_word(OP_LOAD, 13'(RANGE), '0);
		send_word(OP_LOAD, 13'd0, '0);
		send_word(OP_BUILD, '0, '0);
		send_word(OP_READ, '0, 8'd7);
		// two full symbols
		send_word(OP_LOAD, 13'(RANGE), '0);
		send_word(OP_LOAD, 13'(RANGE), '0);
		send_word(OP_BUILD, '0, '0);
		// bad sum with all-ones frequency
		send_word(OP_LOAD, 13'h1FFF, '0);
		send_word(OP_BUILD, '0, '0);
		// ignored opcode
		send_word(2'd3, 13'h1FFF, 8'hFF);
		// normal pairing
		load_valid(4);
		send_word(OP_BUILD, '0, '0);
		for (i = 0; i < 5; i++) send_word(OP_READ, '0, 8'(i));
	endtask

	task automatic test_overflow();
		int i;
		for (i = 0; i < DEF_MAX_SYMBOLS; i++) send_word(OP_LOAD, 13'd16, '0);
		send_word(OP_LOAD, 13'd0, '0);
		send_word(OP_BUILD, '0, '0);
		read_some(4);
		for (i = 0; i < DEF_MAX_SYMBOLS; i++) send_word(OP_LOAD, 13'd16, '0);
		send_word(OP_LOAD, 13'd5, '0);
		send_word(OP_BUILD, '0, '0);
	endtask

	task automatic test_alphabet_sizes();
		logic [3:0] v;
		int k;
		for (k = 0; k < 6; k++) begin
			v = (k == 0) ? 4'd5 : (k == 1) ? 4'd15 : (k == 2) ? 4'd0 : 4'($urandom_range(5, 8));
			write_alphabet_bits(v);
			load_valid($urandom_range(1, 40));
			send_word(OP_BUILD, '0, '0);
			// 33 symbols, too many for the smaller table sizes
			load_valid(33);
			send_word(OP_BUILD, '0, '0);
			read_some(6);
		end
		write_alphabet_bits(4'd8);
	endtask

	task automatic test_random();
		int sent, n;
		sent = 0;
		while (sent < N_RANDOM) begin
			if (sent > N_RANDOM * 4 / 5) idle_on = 0;
			case ($urandom_range(0, 9))
				0: begin
					// noise loads and a build that likely fails
					n = $urandom_range(1, 8);
					repeat (n) send_word(OP_LOAD, 13'($urandom_range(0, 8191)), '0);
					send_word(OP_BUILD, '0, '0);
					sent += n + 1;
				end
				1: begin
					send_word(2'($urandom), 13'($urandom), 8'($urandom));
					sent++;
				end
				default: begin
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 256)
						: $urandom_range(1, 24);
					load_valid(n);
					if ($urandom_range(0, 1)) send_word(OP_LOAD, 13'd0, '0);
					send_word(OP_BUILD, '0, '0);
					read_some(8);
					sent += n + 10;
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_LOAD;
		frequency = '0;
		entry_index = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		alpha_reg = 4'd8;
		load_cnt = 0;
		load_ovf = 0;
		tbl_built = 0;
		fail_cnt = 0;
		idle_on = 1;
		foreach (alias_tbl[i]) alias_tbl[i] = '0;
		foreach (freq_mem[i]) freq_mem[i] = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_overflow();
		test_alphabet_sizes();
		test_random();
		drain();
		if (fail_cnt == 0 && expected_q.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
